[design/dlt_pkg.sv]
// Shared types and constants for the DHCP lease table.
package dlt_pkg;

  localparam int MAC_W = 48;
  localparam int IP_W  = 32;
  localparam int OFF_W = 7;
  localparam int ST_W  = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [OFF_W-1:0] OFFSET_LAST  = 7'd99;
  localparam logic [OFF_W-1:0] OFFSET_WRAP  = 7'd1;
  localparam logic [IP_W-1:0]  ADDR_BIAS    = 32'd8;

  localparam logic [ST_W-1:0] STATUS_EXISTING = 2'd0;
  localparam logic [ST_W-1:0] STATUS_NEW      = 2'd1;
  localparam logic [ST_W-1:0] STATUS_FULL     = 2'd2;

  // register index carried by paddr[2]
  localparam logic REG_GATEWAY = 1'b0;

  typedef struct packed {
    logic start;
    logic scan;
    logic take_hit;
    logic take_miss;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } sts_t;

endpackage

[design/dhcp_lease_table.sv]
// DHCP lease table top level: MAC lookup with address allocation.
// Usage:
//   Input channel in_valid/in_ready carries one client MAC address per item.
//   Result channel out_valid/out_ready returns the leased IPv4 address and a
//   status: existing lease, new lease, or table full (address 0).
//   Register gateway_ip sits at APB byte address 0 and is the base of new
//   addresses (gateway_ip + offset + 8); write it only while the block idles.
// Timing:
//   The table sits in one RAM with a registered read port, scanned one
//   entry per cycle until a hit or the end of the N stored leases, so the
//   time from accept to result grows with N. Items are processed one at a
//   time; in_ready is high only between items.
// Reset:
//   rst_n (synchronous) empties the table, zeroes the offset and gateway.
//   No clearing pass: the fill count marks the valid entries.
// Stall:
//   A finished result waits in the output register; the next item may be
//   accepted and scanned meanwhile and holds until the register frees.
module dhcp_lease_table #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dlt_pkg::MAC_W-1:0]        in_client_mac,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dlt_pkg::IP_W-1:0]         out_assigned_ip,
  output logic [dlt_pkg::ST_W-1:0]         out_lease_status,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dlt_pkg::PADDR_W-1:0]      paddr,
  input  logic [dlt_pkg::PDATA_W-1:0]      pwdata,
  output logic [dlt_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  dlt_pkg::cmd_t cmd;
  dlt_pkg::sts_t sts;
  logic          cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  dlt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dlt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_client_mac    (in_client_mac),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_assigned_ip  (out_assigned_ip),
    .out_lease_status (out_lease_status),
    .cfg_we           (cfg_we),
    .cfg_sel          (paddr[2]),
    .cfg_wdata        (pwdata),
    .cfg_rdata        (prdata)
  );

endmodule

[design/dlt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module dlt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

[design/dlt_ctrl.sv]
// Sequencer for accept, table scan, lease resolve and result hand-off.
module dlt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dlt_pkg::sts_t sts,
  output dlt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = ST_DONE;
        end else if (sts.scan_end) begin
          cmd.take_miss = 1'b1;
          state_nxt     = ST_DONE;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[design/dlt_dp.sv]
// Lease table datapath: storage, scan compare, address allocation, output register.
module dlt_dp #(
  parameter int TABLE_DEPTH = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlt_pkg::cmd_t                     cmd,
  output dlt_pkg::sts_t                     sts,
  input  logic [dlt_pkg::MAC_W-1:0]         in_client_mac,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [dlt_pkg::IP_W-1:0]          out_assigned_ip,
  output logic [dlt_pkg::ST_W-1:0]          out_lease_status,
  input  logic                              cfg_we,
  input  logic                              cfg_sel,
  input  logic [dlt_pkg::PDATA_W-1:0]       cfg_wdata,
  output logic [dlt_pkg::PDATA_W-1:0]       cfg_rdata
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W = dlt_pkg::MAC_W + dlt_pkg::IP_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  logic [dlt_pkg::IP_W-1:0]  gateway_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          rd_idx_r;
  logic                      cmp_valid_r;
  logic [dlt_pkg::OFF_W-1:0] offset_r, offset_nxt;
  logic [dlt_pkg::MAC_W-1:0] mac_r;
  logic [dlt_pkg::IP_W-1:0]  res_ip_r;
  logic [dlt_pkg::ST_W-1:0]  res_st_r;
  logic                      out_valid_r;
  logic [dlt_pkg::IP_W-1:0]  out_ip_r;
  logic [dlt_pkg::ST_W-1:0]  out_st_r;
  logic [DATA_W-1:0]         rd_data;
  logic [dlt_pkg::MAC_W-1:0] rd_mac;
  logic [dlt_pkg::IP_W-1:0]  rd_ip;
  logic [dlt_pkg::IP_W-1:0]  new_ip;
  logic                      full;
  logic                      ins_we;

  assign rd_mac = rd_data[DATA_W-1 -: dlt_pkg::MAC_W];
  assign rd_ip  = rd_data[dlt_pkg::IP_W-1:0];
  assign full   = (count_r == CNT_FULL);
  assign ins_we = cmd.take_miss && !full;
  assign new_ip = gateway_r + dlt_pkg::IP_W'(offset_r) + dlt_pkg::ADDR_BIAS;
  assign offset_nxt = (offset_r == dlt_pkg::OFFSET_LAST) ? dlt_pkg::OFFSET_WRAP
                                                         : offset_r + 1'b1;

  dlt_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ins_we),
    .waddr (count_r[IDX_W-1:0]),
    .wdata ({mac_r, new_ip}),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (rd_data)
  );

  assign sts.hit      = cmp_valid_r && (rd_mac == mac_r);
  assign sts.scan_end = !cmp_valid_r && (rd_idx_r >= count_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_assigned_ip  = out_ip_r;
  assign out_lease_status = out_st_r;
  assign cfg_rdata        = (cfg_sel == dlt_pkg::REG_GATEWAY) ? gateway_r : '0;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gateway_r   <= '0;
      count_r     <= '0;
      offset_r    <= '0;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_sel == dlt_pkg::REG_GATEWAY) begin
        gateway_r <= cfg_wdata;
      end
      if (cmd.start) begin
        rd_idx_r    <= '0;
        cmp_valid_r <= 1'b0;
      end else if (cmd.scan) begin
        cmp_valid_r <= (rd_idx_r < count_r);
        if (rd_idx_r < count_r) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
      end else begin
        cmp_valid_r <= 1'b0;
      end
      if (ins_we) begin
        count_r  <= count_r + 1'b1;
        offset_r <= offset_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mac_r <= in_client_mac;
    end
    if (cmd.take_hit) begin
      res_ip_r <= rd_ip;
      res_st_r <= dlt_pkg::STATUS_EXISTING;
    end else if (cmd.take_miss) begin
      res_ip_r <= full ? '0 : new_ip;
      res_st_r <= full ? dlt_pkg::STATUS_FULL : dlt_pkg::STATUS_NEW;
    end
    if (cmd.emit) begin
      out_ip_r <= res_ip_r;
      out_st_r <= res_st_r;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("lease count beyond table depth");

  a_offset_bound: assert property (@(posedge clk) disable iff (!rst_n)
    offset_r <= dlt_pkg::OFFSET_LAST)
    else $error("offset out of range");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_idx_r <= count_r)
    else $error("scan index past fill count");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_we |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not advance fill count");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

endmodule

[test/tb_dhcp_lease_table.sv]
// Testbench for dhcp_lease_table: random and directed MAC requests checked against a lease model.
`timescale 1ns / 100ps

module tb_dhcp_lease_table;

  localparam int DEPTH          = 128;
  localparam int PHASES         = 8;
  localparam int PER_PHASE      = 240;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 200;

  localparam logic [dlt_pkg::PADDR_W-1:0] GATEWAY_ADDR = {dlt_pkg::REG_GATEWAY, 2'b00};
  localparam logic [dlt_pkg::PADDR_W-1:0] SPARE_ADDR   = {~dlt_pkg::REG_GATEWAY, 2'b00};

  typedef enum logic {ACT_REQUEST, ACT_REG_WRITE} act_kind_t;

  typedef struct {
    act_kind_t                      kind;
    logic [dlt_pkg::MAC_W-1:0]      mac;
    logic [dlt_pkg::PADDR_W-1:0]    addr;
    logic [dlt_pkg::PDATA_W-1:0]    data;
    bit                             calm;
  } stim_t;

  typedef struct {
    logic [dlt_pkg::IP_W-1:0] ip;
    logic [dlt_pkg::ST_W-1:0] status;
  } lease_reply_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [dlt_pkg::MAC_W-1:0]      in_client_mac = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [dlt_pkg::IP_W-1:0]       out_assigned_ip;
  logic [dlt_pkg::ST_W-1:0]       out_lease_status;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [dlt_pkg::PADDR_W-1:0]    paddr = '0;
  logic [dlt_pkg::PDATA_W-1:0]    pwdata = '0;
  logic [dlt_pkg::PDATA_W-1:0]    prdata;
  logic                           pready;

  dhcp_lease_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_client_mac    (in_client_mac),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_assigned_ip  (out_assigned_ip),
    .out_lease_status (out_lease_status),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // lease model
  logic [dlt_pkg::MAC_W-1:0]  tbl_mac  [DEPTH];
  logic [dlt_pkg::IP_W-1:0]   tbl_addr [DEPTH];
  int                         tbl_fill;
  logic [dlt_pkg::OFF_W-1:0]  offset_now;
  logic [dlt_pkg::IP_W-1:0]   gateway_now;

  stim_t                      pending[$];
  lease_reply_t               lease_due[$];
  logic [dlt_pkg::MAC_W-1:0]  known_macs[$];
  int                         mismatches = 0;
  int                         calm_from = 32'h7fff_ffff;
  int                         req_total = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void predict_lease(input logic [dlt_pkg::MAC_W-1:0] mac,
                                        output lease_reply_t r);
    bit hit;
    hit = 1'b0;
    r.ip = '0;
    r.status = dlt_pkg::STATUS_FULL;
    for (int k = 0; k < tbl_fill; k++) begin
      if (!hit && tbl_mac[k] == mac) begin
        hit = 1'b1;
        r.ip = tbl_addr[k];
        r.status = dlt_pkg::STATUS_EXISTING;
      end
    end
    if (!hit && tbl_fill < DEPTH) begin
      r.ip = gateway_now + dlt_pkg::IP_W'(offset_now) + dlt_pkg::ADDR_BIAS;
      r.status = dlt_pkg::STATUS_NEW;
      tbl_mac[tbl_fill] = mac;
      tbl_addr[tbl_fill] = r.ip;
      tbl_fill++;
      offset_now = (offset_now == dlt_pkg::OFFSET_LAST) ? dlt_pkg::OFFSET_WRAP
                                                        : offset_now + 1'b1;
    end
  endfunction

  function automatic void note_mismatch(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h, got %h", field, want, got);
  endfunction

  function automatic void add_request(logic [dlt_pkg::MAC_W-1:0] mac, bit calm);
    stim_t s;
    s.kind = ACT_REQUEST;
    s.mac = mac;
    s.addr = '0;
    s.data = '0;
    s.calm = calm;
    pending.push_back(s);
    known_macs.push_back(mac);
    req_total++;
  endfunction

  function automatic void add_write(logic [dlt_pkg::PADDR_W-1:0] addr,
                                    logic [dlt_pkg::PDATA_W-1:0] data);
    stim_t s;
    s.kind = ACT_REG_WRITE;
    s.mac = '0;
    s.addr = addr;
    s.data = data;
    s.calm = 1'b0;
    pending.push_back(s);
  endfunction

  // stimulus and end of run
  initial begin
    logic [dlt_pkg::MAC_W-1:0]    mac;
    logic [dlt_pkg::PDATA_W-1:0]  gw;
    int                           miss_pct;
    int                           r;
    bit                           calm;

    add_write(GATEWAY_ADDR, 32'h0000_0000);
    add_write(SPARE_ADDR, 32'hffff_ffff);
    add_request(48'h0000_0000_0000, 1'b0);
    add_request(48'hffff_ffff_ffff, 1'b0);
    add_request(48'h0000_0000_0000, 1'b0);
    add_request(48'h0000_0000_0001, 1'b0);
    add_request(48'h8000_0000_0000, 1'b0);
    add_request(48'haaaa_aaaa_aaaa, 1'b0);
    add_request(48'h5555_5555_5555, 1'b0);
    add_request(48'hffff_ffff_ffff, 1'b0);
    add_request(48'h7fff_ffff_ffff, 1'b0);
    add_write(GATEWAY_ADDR, 32'hffff_ffff);
    add_request(48'h0123_4567_89ab, 1'b0);
    add_request(48'hfedc_ba98_7654, 1'b0);
    add_request(48'h0000_0000_0000, 1'b0);
    add_write(GATEWAY_ADDR, 32'hffff_fff0);
    add_request(48'hffff_ffff_fffe, 1'b0);
    add_request(48'h0123_4567_89ab, 1'b0);
    add_request(48'h0000_0000_0002, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: gw = 32'hffff_ffff;
        2: gw = 32'h0a00_0001;
        4: gw = 32'h0000_0000;
        5: gw = 32'hffff_fff8;
        default: gw = $urandom();
      endcase
      add_write(GATEWAY_ADDR, gw);
      if ($urandom_range(0, 1) == 0)
        add_write(SPARE_ADDR, $urandom());
      miss_pct = (p < PHASES - 2) ? 9 : 30;
      calm = (p == PHASES - 1);
      if (calm)
        calm_from = req_total;
      for (int n = 0; n < PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < miss_pct / 2)
          mac = dlt_pkg::MAC_W'({$urandom(), $urandom()});
        else if (r < miss_pct)
          mac = known_macs[$urandom_range(0, known_macs.size() - 1)] ^
                (48'h1 << $urandom_range(0, dlt_pkg::MAC_W - 1));
        else
          mac = known_macs[$urandom_range(0, known_macs.size() - 1)];
        add_request(mac, calm);
      end
    end

    @(negedge clk);
    while (!rst_n || pending.size() > 0 || in_valid || psel || lease_due.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (lease_due.size() > 0) begin
      $display("results missing: %0d", lease_due.size());
      mismatches += lease_due.size();
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // driver
  logic  drv_valid_nxt;
  logic  drv_psel_nxt;
  logic  drv_pen_nxt;
  int    gap_left = 0;
  int    gap_pct = 0;
  int    in_flight = 0;
  int    sent_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      gap_left = 0;
      in_flight = 0;
    end else begin
      drv_valid_nxt = in_valid;
      drv_psel_nxt = psel;
      drv_pen_nxt = penable;
      if (in_valid && in_ready) begin
        drv_valid_nxt = 1'b0;
        in_flight++;
      end
      if (out_valid && out_ready && in_flight > 0)
        in_flight--;
      if (psel && penable && pready) begin
        drv_psel_nxt = 1'b0;
        drv_pen_nxt = 1'b0;
      end else if (psel) begin
        drv_pen_nxt = 1'b1;
      end
      if (!drv_valid_nxt && !psel && pending.size() > 0) begin
        if (pending[0].calm) begin
          gap_left = 0;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!pending[0].calm && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(1, 12) - 1;
        end else if (pending[0].kind == ACT_REQUEST) begin
          drv_valid_nxt = 1'b1;
          in_client_mac <= pending[0].mac;
          void'(pending.pop_front());
          sent_cnt++;
          if (sent_cnt % 150 == 0) begin
            case ($urandom_range(0, 3))
              0: gap_pct = 0;
              1: gap_pct = 4;
              2: gap_pct = 20;
              default: gap_pct = 50;
            endcase
          end
        end else if (in_flight == 0 && !in_valid) begin
          drv_psel_nxt = 1'b1;
          drv_pen_nxt = 1'b0;
          pwrite <= 1'b1;
          paddr <= pending[0].addr;
          pwdata <= pending[0].data;
          void'(pending.pop_front());
        end
      end
      in_valid <= drv_valid_nxt;
      psel <= drv_psel_nxt;
      penable <= drv_pen_nxt;
    end
  end

  // result sink back-pressure
  int stall_left = 0;
  int stall_pct = 0;
  int taken_cnt = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        taken_cnt++;
        if (taken_cnt % 200 == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 5;
            default: stall_pct = 25;
          endcase
        end
      end
      if (taken_cnt >= calm_from) begin
        stall_left = 0;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor and checker
  lease_reply_t want;
  lease_reply_t next_reply;

  always @(posedge clk) begin
    if (!rst_n) begin
      tbl_fill = 0;
      offset_now = '0;
      gateway_now = '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == GATEWAY_ADDR)
          gateway_now = pwdata;
      end
      if (in_valid && in_ready) begin
        predict_lease(in_client_mac, next_reply);
        lease_due.push_back(next_reply);
      end
      if (out_valid && out_ready) begin
        if (lease_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result with nothing pending: ip %h status %0d",
                     out_assigned_ip, out_lease_status);
        end else begin
          want = lease_due.pop_front();
          if (out_assigned_ip !== want.ip)
            note_mismatch("assigned_ip", 64'(want.ip), 64'(out_assigned_ip));
          if (out_lease_status !== want.status)
            note_mismatch("lease_status", 64'(want.status), 64'(out_lease_status));
        end
      end
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule
